FILE: rtl/r2h_pkg.sv
// Shared types, constants and syllable lookup functions for the romaji converter.
package r2h_pkg;

  localparam logic [15:0] SYL_N     = 16'h3093;
  localparam logic [15:0] SMALL_TSU = 16'h3063;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DECIDE,
    FR_FLUSH
  } front_state_t;

  // One decision: one or two code points, or a raw byte.
  typedef struct packed {
    logic [15:0] code0;
    logic [15:0] code1;
    logic        two;
    logic        raw;
    logic        last;
  } dec_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] first;
    logic [15:0] second;
  } syl_t;

  function automatic syl_t mk(input logic [15:0] f, input logic [15:0] s);
    syl_t r;
    r.hit    = 1'b1;
    r.first  = f;
    r.second = s;
    return r;
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic is_vow(input logic [7:0] c);
    return c == "a" || c == "i" || c == "u" || c == "e" || c == "o";
  endfunction

  function automatic logic is_cons(input logic [7:0] c);
    return is_letter(c) && !is_vow(c) && c != "n";
  endfunction

  function automatic syl_t look3(input logic [23:0] k);
    syl_t r;
    r = '0;
    case (k)
      "kya": r = mk(16'h304D, 16'h3083);
      "kyu": r = mk(16'h304D, 16'h3085);
      "kyo": r = mk(16'h304D, 16'h3087);
      "sha": r = mk(16'h3057, 16'h3083);
      "shu": r = mk(16'h3057, 16'h3085);
      "sho": r = mk(16'h3057, 16'h3087);
      "cha": r = mk(16'h3061, 16'h3083);
      "chu": r = mk(16'h3061, 16'h3085);
      "cho": r = mk(16'h3061, 16'h3087);
      "nya": r = mk(16'h306B, 16'h3083);
      "nyu": r = mk(16'h306B, 16'h3085);
      "nyo": r = mk(16'h306B, 16'h3087);
      "hya": r = mk(16'h3072, 16'h3083);
      "hyu": r = mk(16'h3072, 16'h3085);
      "hyo": r = mk(16'h3072, 16'h3087);
      "mya": r = mk(16'h307F, 16'h3083);
      "myu": r = mk(16'h307F, 16'h3085);
      "myo": r = mk(16'h307F, 16'h3087);
      "rya": r = mk(16'h308A, 16'h3083);
      "ryu": r = mk(16'h308A, 16'h3085);
      "ryo": r = mk(16'h308A, 16'h3087);
      "gya": r = mk(16'h304E, 16'h3083);
      "gyu": r = mk(16'h304E, 16'h3085);
      "gyo": r = mk(16'h304E, 16'h3087);
      "jya": r = mk(16'h3058, 16'h3083);
      "jyu": r = mk(16'h3058, 16'h3085);
      "jyo": r = mk(16'h3058, 16'h3087);
      "bya": r = mk(16'h3073, 16'h3083);
      "byu": r = mk(16'h3073, 16'h3085);
      "byo": r = mk(16'h3073, 16'h3087);
      "pya": r = mk(16'h3074, 16'h3083);
      "pyu": r = mk(16'h3074, 16'h3085);
      "pyo": r = mk(16'h3074, 16'h3087);
      "tya": r = mk(16'h3061, 16'h3083);
      "tyu": r = mk(16'h3061, 16'h3085);
      "tyo": r = mk(16'h3061, 16'h3087);
      "dya": r = mk(16'h3062, 16'h3083);
      "dyu": r = mk(16'h3062, 16'h3085);
      "dyo": r = mk(16'h3062, 16'h3087);
      "shi": r = mk(16'h3057, 16'h0000);
      "chi": r = mk(16'h3061, 16'h0000);
      "tsu": r = mk(16'h3064, 16'h0000);
      "thi": r = mk(16'h3066, 16'h3043);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic syl_t look2(input logic [15:0] k);
    syl_t r;
    r = '0;
    case (k)
      "ja": r = mk(16'h3058, 16'h3083);
      "ji": r = mk(16'h3058, 16'h0000);
      "ju": r = mk(16'h3058, 16'h3085);
      "je": r = mk(16'h3058, 16'h3047);
      "jo": r = mk(16'h3058, 16'h3087);
      "ka": r = mk(16'h304B, 16'h0000);
      "ki": r = mk(16'h304D, 16'h0000);
      "ku": r = mk(16'h304F, 16'h0000);
      "ke": r = mk(16'h3051, 16'h0000);
      "ko": r = mk(16'h3053, 16'h0000);
      "sa": r = mk(16'h3055, 16'h0000);
      "si": r = mk(16'h3057, 16'h0000);
      "su": r = mk(16'h3059, 16'h0000);
      "se": r = mk(16'h305B, 16'h0000);
      "so": r = mk(16'h305D, 16'h0000);
      "ta": r = mk(16'h305F, 16'h0000);
      "ti": r = mk(16'h3061, 16'h0000);
      "tu": r = mk(16'h3064, 16'h0000);
      "te": r = mk(16'h3066, 16'h0000);
      "to": r = mk(16'h3068, 16'h0000);
      "na": r = mk(16'h306A, 16'h0000);
      "ni": r = mk(16'h306B, 16'h0000);
      "nu": r = mk(16'h306C, 16'h0000);
      "ne": r = mk(16'h306D, 16'h0000);
      "no": r = mk(16'h306E, 16'h0000);
      "ha": r = mk(16'h306F, 16'h0000);
      "hi": r = mk(16'h3072, 16'h0000);
      "hu": r = mk(16'h3075, 16'h0000);
      "he": r = mk(16'h3078, 16'h0000);
      "ho": r = mk(16'h307B, 16'h0000);
      "ma": r = mk(16'h307E, 16'h0000);
      "mi": r = mk(16'h307F, 16'h0000);
      "mu": r = mk(16'h3080, 16'h0000);
      "me": r = mk(16'h3081, 16'h0000);
      "mo": r = mk(16'h3082, 16'h0000);
      "ya": r = mk(16'h3084, 16'h0000);
      "yu": r = mk(16'h3086, 16'h0000);
      "yo": r = mk(16'h3088, 16'h0000);
      "ra": r = mk(16'h3089, 16'h0000);
      "ri": r = mk(16'h308A, 16'h0000);
      "ru": r = mk(16'h308B, 16'h0000);
      "re": r = mk(16'h308C, 16'h0000);
      "ro": r = mk(16'h308D, 16'h0000);
      "wa": r = mk(16'h308F, 16'h0000);
      "wi": r = mk(16'h3090, 16'h0000);
      "we": r = mk(16'h3091, 16'h0000);
      "wo": r = mk(16'h3092, 16'h0000);
      "nn": r = mk(16'h3093, 16'h0000);
      "ga": r = mk(16'h304C, 16'h0000);
      "gi": r = mk(16'h304E, 16'h0000);
      "gu": r = mk(16'h3050, 16'h0000);
      "ge": r = mk(16'h3052, 16'h0000);
      "go": r = mk(16'h3054, 16'h0000);
      "za": r = mk(16'h3056, 16'h0000);
      "zi": r = mk(16'h3058, 16'h0000);
      "zu": r = mk(16'h305A, 16'h0000);
      "ze": r = mk(16'h305C, 16'h0000);
      "zo": r = mk(16'h305E, 16'h0000);
      "da": r = mk(16'h3060, 16'h0000);
      "di": r = mk(16'h3062, 16'h0000);
      "du": r = mk(16'h3065, 16'h0000);
      "de": r = mk(16'h3067, 16'h0000);
      "do": r = mk(16'h3069, 16'h0000);
      "ba": r = mk(16'h3070, 16'h0000);
      "bi": r = mk(16'h3073, 16'h0000);
      "bu": r = mk(16'h3076, 16'h0000);
      "be": r = mk(16'h3079, 16'h0000);
      "bo": r = mk(16'h307C, 16'h0000);
      "pa": r = mk(16'h3071, 16'h0000);
      "pi": r = mk(16'h3074, 16'h0000);
      "pu": r = mk(16'h3077, 16'h0000);
      "pe": r = mk(16'h307A, 16'h0000);
      "po": r = mk(16'h307D, 16'h0000);
      "fa": r = mk(16'h3075, 16'h3041);
      "fi": r = mk(16'h3075, 16'h3043);
      "fu": r = mk(16'h3075, 16'h0000);
      "fe": r = mk(16'h3075, 16'h3047);
      "fo": r = mk(16'h3075, 16'h3049);
      "la": r = mk(16'h3041, 16'h0000);
      "li": r = mk(16'h3043, 16'h0000);
      "lu": r = mk(16'h3045, 16'h0000);
      "le": r = mk(16'h3047, 16'h0000);
      "lo": r = mk(16'h3049, 16'h0000);
      "xa": r = mk(16'h3041, 16'h0000);
      "xi": r = mk(16'h3043, 16'h0000);
      "xu": r = mk(16'h3045, 16'h0000);
      "xe": r = mk(16'h3047, 16'h0000);
      "xo": r = mk(16'h3049, 16'h0000);
      "va": r = mk(16'h3094, 16'h3041);
      "vi": r = mk(16'h3094, 16'h3043);
      "vu": r = mk(16'h3094, 16'h0000);
      "ve": r = mk(16'h3094, 16'h3047);
      "vo": r = mk(16'h3094, 16'h3049);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic syl_t look1(input logic [7:0] k);
    syl_t r;
    r = '0;
    case (k)
      "a": r = mk(16'h3042, 16'h0000);
      "i": r = mk(16'h3044, 16'h0000);
      "u": r = mk(16'h3046, 16'h0000);
      "e": r = mk(16'h3048, 16'h0000);
      "o": r = mk(16'h304A, 16'h0000);
      "n": r = mk(16'h3093, 16'h0000);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/r2h_front.sv
// Front part: lookahead window, item acceptance and one match decision per cycle, held while the queue is full.
module r2h_front import r2h_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_string,
  output logic       push,
  output dec_t       push_data,
  input  logic       q_full
);

  front_state_t state_r, state_nxt;
  logic [7:0]   win_r [3];
  logic [1:0]   cnt_r, cnt_nxt;
  logic         accept;
  logic         work;
  logic [7:0]   l0, l1, l2;
  logic         has1, has2;
  logic [1:0]   take;
  syl_t         m3, m2, m1;

  assign in_stall = (state_r != FR_IDLE);
  assign accept   = in_valid && !in_stall;
  assign work     = (state_r != FR_IDLE) && !q_full;

  // only held bytes take part in matching
  assign has1 = cnt_r > 2'd1;
  assign has2 = cnt_r > 2'd2;
  assign l0   = to_low(win_r[0]);
  assign l1   = has1 ? to_low(win_r[1]) : 8'h00;
  assign l2   = has2 ? to_low(win_r[2]) : 8'h00;
  assign m3   = look3({l0, l1, l2});
  assign m2   = look2({l0, l1});
  assign m1   = look1(l0);

  always_comb begin
    push_data       = '0;
    take            = 2'd1;
    push_data.code0 = SYL_N;
    if (l0 == "m" && has1 && (l1 == "b" || l1 == "m" || l1 == "p")) begin
      take = 2'd1;
    end else if (l0 == "n" && has1 && ((l1 == "n" && has2 && is_vow(l2)) ||
                 (is_letter(l1) && !is_vow(l1) && l1 != "y" && l1 != "n"))) begin
      take = 2'd1;
    end else if (has1 && is_cons(l0) && l0 == l1) begin
      push_data.code0 = SMALL_TSU;
    end else if (has2 && m3.hit) begin
      take            = 2'd3;
      push_data.code0 = m3.first;
      push_data.code1 = m3.second;
      push_data.two   = (m3.second != 16'h0000);
    end else if (has1 && m2.hit) begin
      take            = 2'd2;
      push_data.code0 = m2.first;
      push_data.code1 = m2.second;
      push_data.two   = (m2.second != 16'h0000);
    end else if (m1.hit) begin
      push_data.code0 = m1.first;
    end else begin
      push_data.code0 = {8'h00, win_r[0]};
      push_data.raw   = 1'b1;
    end
    push_data.last = (state_r == FR_DECIDE) || (cnt_r == take);
  end

  assign push = work;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      FR_IDLE: begin
        if (accept) begin
          cnt_nxt = cnt_r + 2'd1;
          if (in_end_of_string) begin
            state_nxt = FR_FLUSH;
          end else if (cnt_r == 2'd2) begin
            state_nxt = FR_DECIDE;
          end
        end
      end
      FR_DECIDE: begin
        if (work) begin
          cnt_nxt   = cnt_r - take;
          state_nxt = FR_IDLE;
        end
      end
      FR_FLUSH: begin
        if (work) begin
          cnt_nxt = cnt_r - take;
          if (cnt_r == take) begin
            state_nxt = FR_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FR_IDLE;
        cnt_nxt   = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[cnt_r] <= in_char_byte;
    end else if (work) begin
      win_r[0] <= (take == 2'd1) ? win_r[1] : win_r[2];
      win_r[1] <= win_r[2];
    end
  end

endmodule

FILE: rtl/r2h_queue.sv
// Small register queue of decisions between front and back parts.
module r2h_queue import r2h_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  dec_t push_data,
  output logic full,
  input  logic pop,
  output dec_t pop_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dec_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/r2h_back.sv
// Back part: splits decisions into code points and holds the output register.
module r2h_back import r2h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  dec_t        q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code,
  output logic        out_is_raw,
  output logic        out_last_of_run
);

  logic        valid_r;
  logic        sec_r;
  logic [15:0] sec_code_r;
  logic        sec_last_r;
  logic [15:0] code_r;
  logic        raw_r, last_r;
  logic        load;

  assign load      = !valid_r || !out_stall;
  assign pop       = load && !sec_r && !q_empty;
  assign out_valid = valid_r;
  assign out_code  = code_r;
  assign out_is_raw      = raw_r;
  assign out_last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sec_r   <= 1'b0;
    end else if (load) begin
      if (sec_r) begin
        valid_r <= 1'b1;
        sec_r   <= 1'b0;
      end else if (!q_empty) begin
        valid_r <= 1'b1;
        sec_r   <= q_data.two;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_r) begin
        code_r <= sec_code_r;
        raw_r  <= 1'b0;
        last_r <= sec_last_r;
      end else begin
        code_r     <= q_data.code0;
        raw_r      <= q_data.raw;
        last_r     <= q_data.last && !q_data.two;
        sec_code_r <= q_data.code1;
        sec_last_r <= q_data.last;
      end
    end
  end

endmodule

FILE: rtl/romaji_to_hiragana_converter.sv
// Romaji to hiragana converter top level.
// An item that completes a decision reaches the output through the window, the queue and the output register.
// The front part stalls input while it decides on a full window, and after an end-of-string item
//   while the window drains.
// Results leave at up to one per cycle from the output register while out_stall is low.
// Reset: synchronous active-low rst_n empties window, queue and output register.
module romaji_to_hiragana_converter import r2h_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code,
  output logic        out_is_raw,
  output logic        out_last_of_run
);

  logic push, pop, q_full, q_empty;
  dec_t push_data, pop_data;

  r2h_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_string (in_end_of_string),
    .push             (push),
    .push_data        (push_data),
    .q_full           (q_full)
  );

  r2h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  r2h_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code        (out_code),
    .out_is_raw      (out_is_raw),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: rtl/r2h_checker.sv
// Port-level checker for the romaji converter, bound to the top level.
module r2h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_string,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_code,
  input logic        out_is_raw
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_string |=> in_stall)
    else $error("item taken during flush");

  a_raw_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_raw |-> out_code[15:8] == 8'h00)
    else $error("raw result wider than a byte");

  a_kana_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_raw |-> out_code[15:8] == 8'h30)
    else $error("kana result out of block");

endmodule

bind romaji_to_hiragana_converter r2h_checker u_r2h_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_end_of_string (in_end_of_string),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_code         (out_code),
  .out_is_raw       (out_is_raw)
);

FILE: dv/r2h_result_checker.sv
// Checker for the romaji converter: predicts code points from accepted bytes and compares.
`timescale 1ns / 100ps
module r2h_result_checker import r2h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_string,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_code,
  input  logic        out_is_raw,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending_codes
);

  typedef struct packed {
    logic [15:0] code;
    logic        raw;
    logic        last;
  } kana_t;

  kana_t      kana_q[$];
  logic [7:0] held[3];
  int         held_cnt;

  function automatic logic [7:0] lc(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic vowel(input logic [7:0] c);
    return c == "a" || c == "i" || c == "u" || c == "e" || c == "o";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  // Syllable table: returns 1 on a hit (0 for none) and the code points.
  function automatic logic syl_lookup(input string key, output logic [15:0] f,
                                      output logic [15:0] s);
    logic hit;
    hit = 1'b1;
    s = 16'h0;
    f = 16'h0;
    case (key)
      "kya": begin f = 16'h304D; s = 16'h3083; end
      "kyu": begin f = 16'h304D; s = 16'h3085; end
      "kyo": begin f = 16'h304D; s = 16'h3087; end
      "sha": begin f = 16'h3057; s = 16'h3083; end
      "shu": begin f = 16'h3057; s = 16'h3085; end
      "sho": begin f = 16'h3057; s = 16'h3087; end
      "cha": begin f = 16'h3061; s = 16'h3083; end
      "chu": begin f = 16'h3061; s = 16'h3085; end
      "cho": begin f = 16'h3061; s = 16'h3087; end
      "nya": begin f = 16'h306B; s = 16'h3083; end
      "nyu": begin f = 16'h306B; s = 16'h3085; end
      "nyo": begin f = 16'h306B; s = 16'h3087; end
      "hya": begin f = 16'h3072; s = 16'h3083; end
      "hyu": begin f = 16'h3072; s = 16'h3085; end
      "hyo": begin f = 16'h3072; s = 16'h3087; end
      "mya": begin f = 16'h307F; s = 16'h3083; end
      "myu": begin f = 16'h307F; s = 16'h3085; end
      "myo": begin f = 16'h307F; s = 16'h3087; end
      "rya": begin f = 16'h308A; s = 16'h3083; end
      "ryu": begin f = 16'h308A; s = 16'h3085; end
      "ryo": begin f = 16'h308A; s = 16'h3087; end
      "gya": begin f = 16'h304E; s = 16'h3083; end
      "gyu": begin f = 16'h304E; s = 16'h3085; end
      "gyo": begin f = 16'h304E; s = 16'h3087; end
      "ja":  begin f = 16'h3058; s = 16'h3083; end
      "ji":  f = 16'h3058;
      "ju":  begin f = 16'h3058; s = 16'h3085; end
      "je":  begin f = 16'h3058; s = 16'h3047; end
      "jo":  begin f = 16'h3058; s = 16'h3087; end
      "jya": begin f = 16'h3058; s = 16'h3083; end
      "jyu": begin f = 16'h3058; s = 16'h3085; end
      "jyo": begin f = 16'h3058; s = 16'h3087; end
      "bya": begin f = 16'h3073; s = 16'h3083; end
      "byu": begin f = 16'h3073; s = 16'h3085; end
      "byo": begin f = 16'h3073; s = 16'h3087; end
      "pya": begin f = 16'h3074; s = 16'h3083; end
      "pyu": begin f = 16'h3074; s = 16'h3085; end
      "pyo": begin f = 16'h3074; s = 16'h3087; end
      "tya": begin f = 16'h3061; s = 16'h3083; end
      "tyu": begin f = 16'h3061; s = 16'h3085; end
      "tyo": begin f = 16'h3061; s = 16'h3087; end
      "dya": begin f = 16'h3062; s = 16'h3083; end
      "dyu": begin f = 16'h3062; s = 16'h3085; end
      "dyo": begin f = 16'h3062; s = 16'h3087; end
      "shi": f = 16'h3057;
      "chi": f = 16'h3061;
      "tsu": f = 16'h3064;
      "thi": begin f = 16'h3066; s = 16'h3043; end
      "ka": f = 16'h304B; "ki": f = 16'h304D; "ku": f = 16'h304F;
      "ke": f = 16'h3051; "ko": f = 16'h3053;
      "sa": f = 16'h3055; "si": f = 16'h3057; "su": f = 16'h3059;
      "se": f = 16'h305B; "so": f = 16'h305D;
      "ta": f = 16'h305F; "ti": f = 16'h3061; "tu": f = 16'h3064;
      "te": f = 16'h3066; "to": f = 16'h3068;
      "na": f = 16'h306A; "ni": f = 16'h306B; "nu": f = 16'h306C;
      "ne": f = 16'h306D; "no": f = 16'h306E;
      "ha": f = 16'h306F; "hi": f = 16'h3072; "hu": f = 16'h3075;
      "he": f = 16'h3078; "ho": f = 16'h307B;
      "ma": f = 16'h307E; "mi": f = 16'h307F; "mu": f = 16'h3080;
      "me": f = 16'h3081; "mo": f = 16'h3082;
      "ya": f = 16'h3084; "yu": f = 16'h3086; "yo": f = 16'h3088;
      "ra": f = 16'h3089; "ri": f = 16'h308A; "ru": f = 16'h308B;
      "re": f = 16'h308C; "ro": f = 16'h308D;
      "wa": f = 16'h308F; "wi": f = 16'h3090; "we": f = 16'h3091; "wo": f = 16'h3092;
      "nn": f = SYL_N;
      "ga": f = 16'h304C; "gi": f = 16'h304E; "gu": f = 16'h3050;
      "ge": f = 16'h3052; "go": f = 16'h3054;
      "za": f = 16'h3056; "zi": f = 16'h3058; "zu": f = 16'h305A;
      "ze": f = 16'h305C; "zo": f = 16'h305E;
      "da": f = 16'h3060; "di": f = 16'h3062; "du": f = 16'h3065;
      "de": f = 16'h3067; "do": f = 16'h3069;
      "ba": f = 16'h3070; "bi": f = 16'h3073; "bu": f = 16'h3076;
      "be": f = 16'h3079; "bo": f = 16'h307C;
      "pa": f = 16'h3071; "pi": f = 16'h3074; "pu": f = 16'h3077;
      "pe": f = 16'h307A; "po": f = 16'h307D;
      "fa": begin f = 16'h3075; s = 16'h3041; end
      "fi": begin f = 16'h3075; s = 16'h3043; end
      "fu": f = 16'h3075;
      "fe": begin f = 16'h3075; s = 16'h3047; end
      "fo": begin f = 16'h3075; s = 16'h3049; end
      "la": f = 16'h3041; "li": f = 16'h3043; "lu": f = 16'h3045;
      "le": f = 16'h3047; "lo": f = 16'h3049;
      "xa": f = 16'h3041; "xi": f = 16'h3043; "xu": f = 16'h3045;
      "xe": f = 16'h3047; "xo": f = 16'h3049;
      "va": begin f = 16'h3094; s = 16'h3041; end
      "vi": begin f = 16'h3094; s = 16'h3043; end
      "vu": f = 16'h3094;
      "ve": begin f = 16'h3094; s = 16'h3047; end
      "vo": begin f = 16'h3094; s = 16'h3049; end
      "a": f = 16'h3042; "i": f = 16'h3044; "u": f = 16'h3046;
      "e": f = 16'h3048; "o": f = 16'h304A; "n": f = SYL_N;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // One decision on the oldest held byte; returns bytes consumed.
  function automatic int convert_front(input int avail, inout kana_t run[$]);
    logic [7:0]  k[3];
    logic [15:0] f, s;
    string       key;
    int          len;
    k = '{8'h0, 8'h0, 8'h0};
    for (int j = 0; j < avail && j < 3; j++) k[j] = lc(held[j]);
    if (k[0] == "m" && avail > 1 && (k[1] == "b" || k[1] == "m" || k[1] == "p")) begin
      run.push_back('{SYL_N, 1'b0, 1'b0});
      return 1;
    end
    if (k[0] == "n" && avail > 1 &&
        ((k[1] == "n" && avail > 2 && vowel(k[2])) ||
         (!vowel(k[1]) && k[1] != "y" && k[1] != "n" && letter(k[1])))) begin
      run.push_back('{SYL_N, 1'b0, 1'b0});
      return 1;
    end
    if (avail > 1 && letter(k[0]) && !vowel(k[0]) && k[0] != "n" && k[0] == k[1]) begin
      run.push_back('{SMALL_TSU, 1'b0, 1'b0});
      return 1;
    end
    for (len = (avail > 2) ? 3 : avail; len >= 1; len--) begin
      key = "";
      for (int j = 0; j < len; j++) key = {key, string'(k[j])};
      // a zero byte would vanish from the string; it never matches anyway
      if (k[0] != 8'h0 && key.len() == len && syl_lookup(key, f, s)) begin
        run.push_back('{f, 1'b0, 1'b0});
        if (s != 16'h0) run.push_back('{s, 1'b0, 1'b0});
        return len;
      end
    end
    run.push_back('{{8'h0, held[0]}, 1'b1, 1'b0});
    return 1;
  endfunction

  task automatic accept_byte(input logic [7:0] b, input logic eos);
    kana_t run[$];
    int    used;
    if (held_cnt > 2) held_cnt = 2;
    held[held_cnt] = b;
    held_cnt++;
    if (eos) begin
      while (held_cnt > 0 && run.size() < 3) begin
        used = convert_front(held_cnt, run);
        if (used > held_cnt) used = held_cnt;
        for (int j = 0; j + used < held_cnt; j++) held[j] = held[j + used];
        held_cnt -= used;
      end
      held_cnt = 0;
    end else if (held_cnt == 3) begin
      used = convert_front(3, run);
      for (int j = 0; j + used < 3; j++) held[j] = held[j + used];
      held_cnt -= used;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) kana_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    kana_t want;
    if (!rst_n) begin
      held_cnt = 0;
      kana_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (kana_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result code=%h raw=%b last=%b",
                     out_code, out_is_raw, out_last_of_run);
        end else begin
          want = kana_q.pop_front();
          if (want.code !== out_code || want.raw !== out_is_raw ||
              want.last !== out_last_of_run) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp code=%h raw=%b last=%b, got code=%h raw=%b last=%b",
                       want.code, want.raw, want.last, out_code, out_is_raw,
                       out_last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) accept_byte(in_char_byte, in_end_of_string);
    end
    pending_codes = kana_q.size();
  end

  initial begin
    fail_count = 0;
    pending_codes = 0;
    held_cnt = 0;
  end
endmodule

FILE: dv/romaji_to_hiragana_converter_tb.sv
// Testbench top: drives romaji text and random bytes into the converter and reports the verdict.
`timescale 1ns / 100ps
module romaji_to_hiragana_converter_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'h0;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code;
  logic        out_is_raw;
  logic        out_last_of_run;
  int          fail_count;
  int          pending_codes;

  always #5 clk = ~clk;

  romaji_to_hiragana_converter dut (.*);

  r2h_result_checker checker_i (.*);

  string syllables[] = '{"ka", "shi", "tsu", "kya", "chu", "n", "nn", "ja", "jyo", "fa",
                         "thi", "vo", "xe", "wo", "a", "e", "ryo", "pyu", "gu", "dyo",
                         "mba", "mpo", "kk", "tt", "ny", "nna", "nk", "ra", "o", "ze"};

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid drops only for a real gap, so back-to-back items keep it high
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Mixed case noise: turn lower case letters into upper case at random.
  function automatic logic [7:0] jitter_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 3) == 0) return c - 8'd32;
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
    else if (gap_len() == 0) out_stall <= 1'b0;
  end

  initial begin
    string s;
    int    sent;
    int    n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_text("n");
    send_text("kyouto");
    send_text("KaNpai");
    send_text("kitte");
    send_text("konnichiwa");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_text("Shi!");
    sent = 36;
    while (sent < 330) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 5);
        s = "";
        for (int i = 0; i < n; i++) s = {s, syllables[$urandom_range(0, syllables.size() - 1)]};
        for (int i = 0; i < s.len(); i++) begin
          send_byte(jitter_case(s[i]), i == s.len() - 1);
          sent++;
        end
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(0, 255)), (i == n - 1) && $urandom_range(0, 1));
          sent++;
        end
      end
    end
    // ensure the window is flushed before the end
    send_byte("a", 1'b1);
    in_valid <= 1'b0;
    while (pending_codes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_codes == 0) begin
      $display("romaji_to_hiragana_converter_tb OK");
    end else begin
      $display("romaji_to_hiragana_converter_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("romaji_to_hiragana_converter_tb NOT OK");
    $finish;
  end
endmodule
